// File: hdl/swm_pkg.sv
// Shared types and constants for the sliding window median filter.
package swm_pkg;

    // Window size register: width, reset value and position on the APB bus
    localparam int WS_BITS = 6;
    localparam logic [WS_BITS-1:0] WS_RESET = 6'd5;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic REG_WINDOW_SIZE = 1'b0;   // register index taken from paddr[2]

    // Commands broadcast to every sorting cell, in priority order
    typedef struct packed {
        logic clear;    // empty the cell
        logic insert;   // place the broadcast value in sorted order
        logic shift;    // take the right neighbor's contents
    } cell_ctrl_t;

endpackage

// File: hdl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/swm_cell.sv
// One insertion-sort cell: holds a value, keeps the row sorted ascending.
module swm_cell #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::cell_ctrl_t ctrl,
    input  logic signed [W-1:0] x,          // broadcast value being inserted
    input  logic signed [W-1:0] left_val,
    input  logic                left_vld,
    input  logic                left_cmp,
    input  logic signed [W-1:0] right_val,
    input  logic                right_vld,
    output logic signed [W-1:0] val,
    output logic                vld,
    output logic                cmp
);

    logic signed [W-1:0] val_reg, val_next;
    logic                vld_reg, vld_next;

    // empty cells act as +infinity, so the row stays sorted with empties at the end
    assign cmp = !vld_reg || (x < val_reg);

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.clear)
        begin
            vld_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (cmp)
            begin
                if (left_cmp)
                begin
                    val_next = left_val;
                    vld_next = left_vld;
                end
                else
                begin
                    val_next = x;
                    vld_next = 1'b1;
                end
            end
        end
        else if (ctrl.shift)
        begin
            val_next = right_val;
            vld_next = right_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

// File: hdl/sliding_window_median.sv
// Top level: streaming median over the newest window_size samples.
// A beat that completes a window (k = effective window size) stalls the input while the
//   sequencer reads the newest k samples from the store, inserts each into the sort row,
//   then shifts the row to the middle and loads the result; a beat with no result never
//   stalls the input. The load waits while a held result is stalled at the output.
// Reset: empties the window, sets window_size to 5, clears out_valid and in_stall.
module sliding_window_median #(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swm_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [swm_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [swm_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                first_of_sequence,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS:0]         median_twice
);

    import swm_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW = $clog2(MAX_WINDOW + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a beat
    localparam logic [1:0] S_READ  = 2'd1;  // reading the newest k samples, newest first
    localparam logic [1:0] S_LAST  = 2'd2;  // last read data lands in the sort row
    localparam logic [1:0] S_SHIFT = 2'd3;  // shift the row left to the middle, then emit

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WS_BITS-1:0] ws_reg, ws_next;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign ws_next = cfg_wr ? pwdata[WS_BITS-1:0] : ws_reg;
    assign prdata = (paddr[2] == REG_WINDOW_SIZE)
                  ? {{(PDATA_BITS-WS_BITS){1'b0}}, ws_reg} : '0;

    // Effective window: zero means one, anything past the store saturates
    logic [31:0]   ws_ext;
    logic [KW-1:0] eff_k;

    assign ws_ext = {{(32-WS_BITS){1'b0}}, ws_reg};
    assign eff_k  = (ws_reg == '0)               ? KW'(1)
                  : (ws_ext > 32'(MAX_WINDOW))   ? KW'(MAX_WINDOW)
                  : KW'(ws_reg);

    // ------------------------------------------------------------------
    // Sample store: circular buffer, fill count tracks how many are live.
    // A first-of-sequence beat restarts the count; stale entries are never read.
    // ------------------------------------------------------------------
    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [KW-1:0] fill_reg, fill_next, new_fill;
    logic          accept, hit;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign new_fill = first_of_sequence ? KW'(1)
                    : (fill_reg == KW'(MAX_WINDOW)) ? fill_reg
                    : fill_reg + KW'(1);
    assign hit = (new_fill >= eff_k);

    assign fill_next = accept ? new_fill : fill_reg;
    assign wptr_next = !accept ? wptr_reg
                     : (wptr_reg == AW'(MAX_WINDOW - 1)) ? '0
                     : wptr_reg + AW'(1);

    logic [AW-1:0]          rd_addr_reg, rd_addr_next;
    logic                   ram_re;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (wptr_reg),
        .wdata (sample),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] rd_left_reg, rd_left_next;
    logic [KW-1:0] sh_left_reg, sh_left_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          out_valid_reg, out_valid_next;
    logic          load;
    cell_ctrl_t    ctrl;

    logic signed [SAMPLE_BITS:0] median_reg, median_next;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        rd_addr_next = rd_addr_reg;
        rd_left_next = rd_left_reg;
        sh_left_next = sh_left_reg;
        ram_re       = 1'b0;
        load         = 1'b0;
        ctrl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && hit)
                begin
                    ctrl.clear   = 1'b1;
                    k_next       = eff_k;
                    rd_addr_next = wptr_reg;       // slot being written now
                    rd_left_next = eff_k;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                ram_re       = 1'b1;
                ctrl.insert  = rd_vld_reg;
                rd_addr_next = (rd_addr_reg == '0) ? AW'(MAX_WINDOW - 1)
                                                   : rd_addr_reg - AW'(1);
                rd_left_next = rd_left_reg - KW'(1);
                if (rd_left_reg == KW'(1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                ctrl.insert  = 1'b1;
                // lower middle element sits at index (k-1)/2 once sorted
                sh_left_next = KW'((k_reg - KW'(1)) >> 1);
                state_next   = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sh_left_reg != '0)
                begin
                    ctrl.shift   = 1'b1;
                    sh_left_next = sh_left_reg - KW'(1);
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_vld_next    = (state_reg == S_READ);
    assign out_valid_next = load || (out_valid_reg && out_stall);

    // ------------------------------------------------------------------
    // Sort row: cell 0 holds the smallest live value
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         cell_vld;
    logic [MAX_WINDOW-1:0]         cell_cmp;
    logic signed [SAMPLE_BITS-1:0] x;

    assign x = ram_rdata;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] lv, rv;
        logic                          lvld, lcmp, rvld;

        if (i == 0)
        begin : g_first
            assign lv   = x;
            assign lvld = 1'b0;
            assign lcmp = 1'b0;
        end
        else
        begin : g_mid
            assign lv   = cell_val[i-1];
            assign lvld = cell_vld[i-1];
            assign lcmp = cell_cmp[i-1];
        end

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign rv   = '0;
            assign rvld = 1'b0;
        end
        else
        begin : g_inner
            assign rv   = cell_val[i+1];
            assign rvld = cell_vld[i+1];
        end

        swm_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .x         (x),
            .left_val  (lv),
            .left_vld  (lvld),
            .left_cmp  (lcmp),
            .right_val (rv),
            .right_vld (rvld),
            .val       (cell_val[i]),
            .vld       (cell_vld[i]),
            .cmp       (cell_cmp[i])
        );
    end

    // After the shifts the lower middle is in cell 0, the upper middle in cell 1
    logic signed [SAMPLE_BITS-1:0] mid_lo, mid_hi;

    assign mid_lo = cell_val[0];
    if (MAX_WINDOW > 1)
    begin : g_hi
        assign mid_hi = cell_val[1];
    end
    else
    begin : g_hi_one
        assign mid_hi = cell_val[0];
    end

    // odd window: twice the middle; even: sum of the two middles
    assign median_next = {mid_lo[SAMPLE_BITS-1], mid_lo}
                       + (k_reg[0] ? {mid_lo[SAMPLE_BITS-1], mid_lo}
                                   : {mid_hi[SAMPLE_BITS-1], mid_hi});

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= WS_RESET;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            rd_left_reg   <= '0;
            sh_left_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            k_reg         <= k_next;
            rd_left_reg   <= rd_left_next;
            sh_left_reg   <= sh_left_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        if (load)
        begin
            median_reg <= median_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_twice = median_reg;

endmodule

// File: hdl/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
module swm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic signed [SAMPLE_BITS:0] median_twice
);

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(median_twice))
        else $error("result changed while stalled");

    // results are produced only by the sort sequence, which stalls the input
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while input side was idle");

    // finishing a result frees the input side at once
    a_rise_free: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("input still stalled after result was loaded");

    // checks a minimum delay from an accepted input beat to a rising result
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result too soon after input beat");

endmodule

bind sliding_window_median swm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_twice (median_twice)
);

// File: tb/sv/sliding_window_median_tb.sv
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 100ps

module sliding_window_median_tb;

    import swm_pkg::*;

    localparam int MAX_WIN  = 32;
    localparam int SAMPLE_W = 16;
    // Margin over the slowest result, at a full 32-sample window.
    localparam int DRAIN_CYCLES = 80;
    // Byte address of the window_size register.
    localparam logic [PADDR_BITS-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_BITS-1:0]      paddr;
    logic [PDATA_BITS-1:0]      pwdata;
    logic [PDATA_BITS-1:0]      prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first_of_sequence;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W:0]   median_twice;

    sliding_window_median #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .first_of_sequence (first_of_sequence),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .median_twice      (median_twice)
    );

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the sample store inside the block.
    // Slots fill in order until the store is full, then the oldest slot
    // is overwritten. Ages saturate at MAX_WIN-1.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] win_val [MAX_WIN];
    logic [4:0]                 win_age [MAX_WIN];
    int                         held_count;
    logic [WS_BITS-1:0]         cfg_window_size;

    // Medians (times two) still owed by the block, oldest first.
    logic signed [SAMPLE_W:0]   pending_medians [$];
    logic signed [SAMPLE_W:0]   owed_median;

    int mismatch_count;
    int send_idle_pct;   // chance in 100 that the sender skips a cycle
    int stall_pct;       // chance in 100 that the receiver stalls a cycle

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run (~1100 beats, some stalled by a
    // full sort sequence, plus idling on both sides).
    initial
    begin
        #5000000;
        $display("sliding_window_median verification failed");
        $finish;
    end

    function automatic void note_mismatch(input string what, input int want, input int got);
        if (mismatch_count < 10)
            $display("%0t MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endfunction

    // Take one sample into the mirrored window and work out whether a
    // result follows it, and its value.
    function automatic bit advance_window(input logic signed [SAMPLE_W-1:0] s,
                                          input logic fos,
                                          output logic signed [SAMPLE_W:0] med2);
        logic signed [SAMPLE_W-1:0] ordered [MAX_WIN];
        logic signed [SAMPLE_W-1:0] v;
        int slot;
        int k;
        int n;
        int i;
        int j;
        med2 = '0;
        // first_of_sequence wipes the store before the sample goes in
        if (fos)
        begin
            for (i = 0; i < MAX_WIN; i++)
            begin
                win_val[i] = '0;
                win_age[i] = '0;
            end
            held_count = 0;
        end
        slot = 0;
        if (held_count < MAX_WIN)
        begin
            slot = held_count;
            held_count++;
        end
        else
        begin
            // full store: the last slot holding the highest age is replaced
            for (i = 0; i < MAX_WIN; i++)
                if (win_age[i] >= win_age[slot])
                    slot = i;
        end
        for (i = 0; i < held_count; i++)
            if (i != slot && win_age[i] < MAX_WIN - 1)
                win_age[i]++;
        win_val[slot] = s;
        win_age[slot] = '0;

        // size 0 acts as 1, sizes past the store saturate
        if (cfg_window_size == 0)
            k = 1;
        else if (cfg_window_size > MAX_WIN)
            k = MAX_WIN;
        else
            k = cfg_window_size;
        if (held_count < k)
            return 1'b0;

        // insertion sort of the k newest samples
        n = 0;
        for (i = 0; i < held_count; i++)
        begin
            if (win_age[i] < k)
            begin
                v = win_val[i];
                j = n;
                while (j > 0 && ordered[j-1] > v)
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = v;
                n++;
            end
        end
        if (n == 0)
            return 1'b0;
        if (n % 2 == 1)
            med2 = ordered[n/2] + ordered[n/2];
        else
            med2 = ordered[n/2-1] + ordered[n/2];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, and the result check. Signals are read
    // right after the edge, so they hold their pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_medians.size() == 0)
                note_mismatch("result with nothing pending", 0, int'(median_twice));
            else
            begin
                owed_median = pending_medians.pop_front();
                if (median_twice !== owed_median)
                    note_mismatch("median_twice", int'(owed_median), int'(median_twice));
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one beat, with random idle cycles ahead of it, and hold it
    // until accepted. On acceptance the expected result (if any) is queued.
    task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic fos);
        logic signed [SAMPLE_W:0] med2;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        sample            <= s;
        first_of_sequence <= fos;
        do
            @(posedge clk);
        while (in_stall);
        if (advance_window(s, fos, med2))
            pending_medians = {pending_medians, med2};
    endtask

    // Drop valid, let every owed result come out, then give the block time
    // to finish any work on beats that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_window_size(input logic [WS_BITS-1:0] size);
        logic [PDATA_BITS-1:0] word;
        word = $urandom;   // upper bits are junk the register must ignore
        word[WS_BITS-1:0] = size;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_SIZE_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_window_size = size;
    endtask

    // APB read of window_size, compared with the mirrored value.
    task automatic check_window_size();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= WINDOW_SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== PDATA_BITS'(cfg_window_size))
            note_mismatch("window_size readback", int'(cfg_window_size), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mix of plain random words, small values (lots of ties), extremes and held values.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 4))
            0, 1:    return SAMPLE_W'($urandom);
            2:       return SAMPLE_W'($urandom_range(0, 16) - 8);
            3:       return SAMPLE_W'($urandom_range(0, 1) ? 32767 - $urandom_range(0, 2)
                                                        : -32768 + $urandom_range(0, 2));
            default: return win_val[$urandom_range(0, MAX_WIN - 1)];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register comes out of reset at 5.
    task automatic test_reset_value();
        check_window_size();
    endtask

    // Hand-picked beats: field extremes, clear mid-stream, even and odd
    // windows, size 0 acting as 1, size changed while samples are held.
    task automatic test_directed();
        // window of 5 from reset; no result until five samples are held
        send_beat(16'sh7FFF, 1'b1);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh7FFF, 1'b0);   // top of range doubled
        send_beat(16'sh8000, 1'b0);   // bottom of range doubled
        send_beat(16'sh0000, 1'b0);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sh0001, 1'b0);
        // clear: the window starts over and must refill
        send_beat(16'sh5555, 1'b1);
        send_beat(16'shAAAA, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(16'sh0000, 1'b0);
        send_beat(-16'sd1, 1'b0);
        settle();

        // even window on samples already held: sum of the two middle ones
        write_window_size(6'd2);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh7FFF, 1'b0);
        send_beat(16'sh8000, 1'b0);
        send_beat(16'sh8000, 1'b0);
        settle();

        // size 0 behaves as a window of one
        write_window_size(6'd0);
        check_window_size();
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sh7FFF, 1'b1);
        settle();
    endtask

    // Random phases over window sizes and idling patterns. Sizes lean
    // small; a few phases run the full store and the saturating sizes.
    task automatic test_random_phases();
        int sizes [18] = '{3, 1, 0, 2, 7, 32, 4, 63, 6, 17, 5, 33, 8, 31, 2, 9, 4, 12};
        int eff;
        int fos_pct;
        int count;
        int p;
        int i;
        for (p = 0; p < 18; p++)
        begin
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 45;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 45;
                end
                default:
                begin
                    send_idle_pct = 32;
                    stall_pct     = 32;
                end
            endcase
            write_window_size(WS_BITS'(sizes[p]));
            check_window_size();
            eff = (sizes[p] == 0) ? 1 : ((sizes[p] > MAX_WIN) ? MAX_WIN : sizes[p]);
            // big windows need long runs between clears to ever fill
            fos_pct = (eff >= 16) ? 1 : 4;
            count   = (eff >= 16) ? 80 : 55;
            for (i = 0; i < count; i++)
                send_beat(pick_sample(),
                          (i == 0 && $urandom_range(0, 1)) || ($urandom_range(99) < fos_pct));
            settle();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_valid          <= 1'b0;
        sample            <= '0;
        first_of_sequence <= 1'b0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        mismatch_count    = 0;
        cfg_window_size   = WS_RESET;
        held_count        = 0;
        for (int i = 0; i < MAX_WIN; i++)
        begin
            win_val[i] = '0;
            win_age[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_value();
        test_directed();
        test_random_phases();

        settle();
        if (mismatch_count == 0)
            $display("sliding_window_median verification clean");
        else
            $display("sliding_window_median verification failed");
        $finish;
    end

endmodule
